/* hw/rtl/ppg_pkg.sv */
// Shared types, codes and reset values for the perception plausibility gate.
`timescale 1ns / 1ps

package ppg_pkg;

	// Reject reasons in check order.
	typedef enum logic [2:0] {
		RC_NONE     = 3'd0,
		RC_INVALID  = 3'd1,
		RC_STALE    = 3'd2,
		RC_SEQUENCE = 3'd3,
		RC_LOWCONF  = 3'd4,
		RC_DISAGREE = 3'd5,
		RC_DRIFT    = 3'd6
	} reject_code_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_MAX_AGE      = 2'd0,
		REG_MIN_CONF     = 2'd1,
		REG_MAX_DISAGREE = 2'd2,
		REG_MAX_DRIFT    = 2'd3
	} reg_index_t;

	localparam int unsigned AddrWidth = 4;

	// Confidence of 1.0 in Q1.15.
	localparam logic [15:0] CONF_ONE = 16'd32768;

	// Reset values of the configuration registers.
	localparam logic [31:0] RST_MAX_AGE      = 32'd100;
	localparam logic [15:0] RST_MIN_CONF     = 16'd16384;
	localparam logic [15:0] RST_MAX_DISAGREE = 16'd6554;
	localparam logic [30:0] RST_MAX_DRIFT    = 31'd65536;

	// Threshold set seen by the check logic.
	typedef struct packed {
		logic [31:0] max_age_ms;
		logic [15:0] min_confidence;
		logic [15:0] max_disagreement;
		logic [30:0] max_drift;
	} cfg_t;

	// One candidate as held in the input register.
	typedef struct packed {
		logic [31:0]        now_ms;
		logic [31:0]        stamp_ms;
		logic [31:0]        seq_number;
		logic signed [16:0] primary_conf;
		logic signed [16:0] secondary_conf;
		logic signed [31:0] drift_metric;
		logic [2:0]         nonfinite_flags;
	} cand_t;

	// Sequence tracking state handed to the check logic.
	typedef struct packed {
		logic [31:0] last_seq;
		logic        seen_any;
	} seq_state_t;

endpackage

/* hw/rtl/ppg_channels.sv */
// Request channels of the perception plausibility gate: candidate in, verdict out.
`timescale 1ns / 1ps

interface ppg_cand_if;
	logic               valid;
	logic               ready;
	logic [31:0]        now_ms;
	logic [31:0]        stamp_ms;
	logic [31:0]        seq_number;
	logic signed [16:0] primary_conf;
	logic signed [16:0] secondary_conf;
	logic signed [31:0] drift_metric;
	logic [2:0]         nonfinite_flags;

	modport source (
		output valid, now_ms, stamp_ms, seq_number, primary_conf, secondary_conf,
		       drift_metric, nonfinite_flags,
		input  ready
	);
	modport sink (
		input  valid, now_ms, stamp_ms, seq_number, primary_conf, secondary_conf,
		       drift_metric, nonfinite_flags,
		output ready
	);
endinterface

interface ppg_verdict_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  reject_code;
	logic        escalate;
	logic [31:0] escalation_seq;
	logic [31:0] accept_total;
	logic [31:0] reject_total;

	modport source (
		output valid, accepted, reject_code, escalate, escalation_seq, accept_total,
		       reject_total,
		input  ready
	);
	modport sink (
		input  valid, accepted, reject_code, escalate, escalation_seq, accept_total,
		       reject_total,
		output ready
	);
endinterface

/* hw/rtl/perception_plausibility_gate.sv */
// Top level of the perception plausibility gate: input register, checks, verdict register.
`timescale 1ns / 1ps

// The gate takes one perception candidate request per cycle while the verdict side is not
// stalled, and returns one verdict request for each, in order. An accepted candidate is
// held in the input register and checked there against the thresholds and the sequence
// state, and its verdict is then registered in the verdict register, which offers it.
// Throughput is one candidate per cycle while verdicts are taken; it is set by the single
// check stage, which also updates the last sequence number and the accept and reject
// counters as each candidate leaves it. A stalled verdict holds the check stage, and a held
// check stage holds the input. Thresholds are to be written through the APB-style port only
// while no candidate is in flight; the user must keep to this, the gate does not enforce it.
module perception_plausibility_gate (
	input  logic                          clk,
	input  logic                          arst_n,
	ppg_cand_if.sink                      cand,
	ppg_verdict_if.source                 verdict,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppg_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	ppg_pkg::cfg_t         cfg;
	ppg_pkg::cand_t        item_s1;
	logic                  vld_s1;
	ppg_pkg::seq_state_t   seq_st;
	ppg_pkg::reject_code_t code;

	logic [31:0] last_seq_q;
	logic        seen_any_q;
	logic [31:0] accept_q;
	logic [31:0] reject_q;

	logic        vld_s2;
	logic        accepted_s2;
	logic [2:0]  code_s2;
	logic        escalate_s2;
	logic [31:0] esc_seq_s2;
	logic [31:0] accept_total_s2;
	logic [31:0] reject_total_s2;

	logic s2_free;
	logic adv;
	logic is_reject;

	// Threshold registers.
	ppg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control across the two stages.
	assign s2_free    = !vld_s2 || verdict.ready;
	assign adv        = vld_s1 && s2_free;
	assign cand.ready = !vld_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cand.ready) begin
			vld_s1 <= cand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cand.valid && cand.ready) begin
			item_s1.now_ms          <= cand.now_ms;
			item_s1.stamp_ms        <= cand.stamp_ms;
			item_s1.seq_number      <= cand.seq_number;
			item_s1.primary_conf    <= cand.primary_conf;
			item_s1.secondary_conf  <= cand.secondary_conf;
			item_s1.drift_metric    <= cand.drift_metric;
			item_s1.nonfinite_flags <= cand.nonfinite_flags;
		end
	end

	// Checks on the registered candidate.
	assign seq_st.last_seq = last_seq_q;
	assign seq_st.seen_any = seen_any_q;

	ppg_eval u_eval (
		.item   (item_s1),
		.cfg    (cfg),
		.seq_st (seq_st),
		.code   (code)
	);

	assign is_reject = (code != ppg_pkg::RC_NONE);

	// Sequence tracking and counters, updated as a candidate leaves the check stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q <= 32'd0;
			seen_any_q <= 1'b0;
			accept_q   <= 32'd0;
			reject_q   <= 32'd0;
		end else if (adv) begin
			if (!seen_any_q || (item_s1.seq_number > last_seq_q)) begin
				last_seq_q <= item_s1.seq_number;
				seen_any_q <= 1'b1;
			end
			if (is_reject) begin
				reject_q <= reject_q + 32'd1;
			end else begin
				accept_q <= accept_q + 32'd1;
			end
		end
	end

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted_s2     <= !is_reject;
			code_s2         <= code;
			escalate_s2     <= is_reject;
			esc_seq_s2      <= is_reject ? reject_q : 32'd0;
			accept_total_s2 <= is_reject ? accept_q : accept_q + 32'd1;
			reject_total_s2 <= is_reject ? reject_q + 32'd1 : reject_q;
		end
	end

	assign verdict.valid          = vld_s2;
	assign verdict.accepted       = accepted_s2;
	assign verdict.reject_code    = code_s2;
	assign verdict.escalate       = escalate_s2;
	assign verdict.escalation_seq = esc_seq_s2;
	assign verdict.accept_total   = accept_total_s2;
	assign verdict.reject_total   = reject_total_s2;

	// An accepted verdict carries no reason and no escalation.
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict.valid && verdict.accepted) |->
			(!verdict.escalate && (verdict.reject_code == ppg_pkg::RC_NONE)))
		else $error("accepted verdict with a reject reason or escalation");

	// The escalation number is the reject count before this reject.
	a_esc_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict.valid && verdict.escalate) |->
			((verdict.escalation_seq + 32'd1) == verdict.reject_total))
		else $error("escalation number out of step with reject count");

	// Each candidate leaving the check stage bumps exactly one counter.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> ((accept_q + reject_q) == ($past(accept_q) + $past(reject_q) + 32'd1)))
		else $error("counters did not advance by one");

	// The last sequence number never moves backward once seen.
	a_seq_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(seen_any_q) |-> (last_seq_q >= $past(last_seq_q)))
		else $error("last sequence number moved backward");

endmodule

/* hw/rtl/ppg_cfg.sv */
// APB-style configuration registers holding the gate thresholds.
`timescale 1ns / 1ps

module ppg_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppg_pkg::AddrWidth-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output ppg_pkg::cfg_t                   cfg
);

	ppg_pkg::cfg_t      cfg_q;
	ppg_pkg::reg_index_t reg_sel;
	logic               wr_en;

	assign reg_sel = ppg_pkg::reg_index_t'(paddr[3:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_age_ms       <= ppg_pkg::RST_MAX_AGE;
			cfg_q.min_confidence   <= ppg_pkg::RST_MIN_CONF;
			cfg_q.max_disagreement <= ppg_pkg::RST_MAX_DISAGREE;
			cfg_q.max_drift        <= ppg_pkg::RST_MAX_DRIFT;
		end else if (wr_en) begin
			unique case (reg_sel)
				ppg_pkg::REG_MAX_AGE:      cfg_q.max_age_ms       <= pwdata;
				ppg_pkg::REG_MIN_CONF:     cfg_q.min_confidence   <= pwdata[15:0];
				ppg_pkg::REG_MAX_DISAGREE: cfg_q.max_disagreement <= pwdata[15:0];
				ppg_pkg::REG_MAX_DRIFT:    cfg_q.max_drift        <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// Read back, zero extended.
	always_comb begin
		unique case (reg_sel)
			ppg_pkg::REG_MAX_AGE:      prdata = cfg_q.max_age_ms;
			ppg_pkg::REG_MIN_CONF:     prdata = {16'd0, cfg_q.min_confidence};
			ppg_pkg::REG_MAX_DISAGREE: prdata = {16'd0, cfg_q.max_disagreement};
			ppg_pkg::REG_MAX_DRIFT:    prdata = {1'b0, cfg_q.max_drift};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

/* hw/rtl/ppg_eval.sv */
// Plausibility checks of one candidate, first failure wins.
`timescale 1ns / 1ps

module ppg_eval (
	input  ppg_pkg::cand_t        item,
	input  ppg_pkg::cfg_t         cfg,
	input  ppg_pkg::seq_state_t   seq_st,
	output ppg_pkg::reject_code_t code
);

	logic [31:0] age;
	logic        future;
	logic        stale;
	logic        seq_bad;
	logic        conf_bad;
	logic        low_conf;
	logic [17:0] diff;
	logic [17:0] abs_diff;
	logic        disagree;
	logic        drift_bad;
	logic        drift_high;

	// Individual conditions; each only counts at its place in the chain.
	always_comb begin
		future  = item.now_ms < item.stamp_ms;
		age     = item.now_ms - item.stamp_ms;
		stale   = age > cfg.max_age_ms;
		seq_bad = seq_st.seen_any && (item.seq_number <= seq_st.last_seq);

		conf_bad = (item.nonfinite_flags[1:0] != 2'b00)
			|| item.primary_conf[16] || (item.primary_conf[15:0] > ppg_pkg::CONF_ONE)
			|| item.secondary_conf[16] || (item.secondary_conf[15:0] > ppg_pkg::CONF_ONE);
		low_conf = (item.primary_conf[15:0] < cfg.min_confidence)
			|| (item.secondary_conf[15:0] < cfg.min_confidence);

		diff     = {item.primary_conf[16], item.primary_conf}
			- {item.secondary_conf[16], item.secondary_conf};
		abs_diff = diff[17] ? (18'd0 - diff) : diff;
		disagree = abs_diff > {2'b00, cfg.max_disagreement};

		drift_bad  = item.nonfinite_flags[2] || item.drift_metric[31];
		drift_high = item.drift_metric[30:0] > cfg.max_drift;
	end

	// Priority chain in check order.
	always_comb begin
		if (future) begin
			code = ppg_pkg::RC_INVALID;
		end else if (stale) begin
			code = ppg_pkg::RC_STALE;
		end else if (seq_bad) begin
			code = ppg_pkg::RC_SEQUENCE;
		end else if (conf_bad) begin
			code = ppg_pkg::RC_INVALID;
		end else if (low_conf) begin
			code = ppg_pkg::RC_LOWCONF;
		end else if (disagree) begin
			code = ppg_pkg::RC_DISAGREE;
		end else if (drift_bad) begin
			code = ppg_pkg::RC_INVALID;
		end else if (drift_high) begin
			code = ppg_pkg::RC_DRIFT;
		end else begin
			code = ppg_pkg::RC_NONE;
		end
	end

endmodule

/* verif/tb_perception_plausibility_gate.sv */
// Self-checking testbench for the perception plausibility gate.
`timescale 1ns / 1ps

module tb_perception_plausibility_gate;
	import ppg_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned PHASE_ITEMS  = 125;
	localparam int unsigned PHASE_COUNT  = 8;
	localparam int unsigned SHOWN_ERRORS = 10;

	// One verdict as seen on the outgoing channel.
	typedef struct packed {
		logic         accepted;
		reject_code_t code;
		logic         escalate;
		logic [31:0]  escalation_seq;
		logic [31:0]  accept_total;
		logic [31:0]  reject_total;
	} verdict_t;

	// Ways in which a well-formed candidate is spoiled by the stimulus.
	typedef enum int {
		F_CLEAN, F_FUTURE, F_STALE, F_REPLAY, F_RANGE,
		F_LOWCONF, F_SPLIT, F_BADDRIFT, F_OVERDRIFT, F_FLAGS
	} fault_t;

	// Tracks the gate state, predicts each verdict and compares it with the DUT.
	class verdict_scoreboard;
		cfg_t        cfg;
		logic [31:0] last_seq;
		logic        seen_any;
		logic [31:0] accept_count;
		logic [31:0] reject_count;
		logic [31:0] escalation_count;
		verdict_t    pending_verdicts[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned accepts_seen;
		int unsigned reject_hits[8];

		function new();
			cfg = '{RST_MAX_AGE, RST_MIN_CONF, RST_MAX_DISAGREE, RST_MAX_DRIFT};
			last_seq = '0;
			seen_any = 1'b0;
			accept_count = '0;
			reject_count = '0;
			escalation_count = '0;
			errors = 0;
			checked = 0;
			accepts_seen = 0;
			foreach (reject_hits[i]) reject_hits[i] = 0;
		endfunction

		function int unsigned pending();
			return pending_verdicts.size();
		endfunction

		function void report_mismatch(string what);
			errors++;
			if (errors <= SHOWN_ERRORS) begin
				$display("[%0t] mismatch: %s", $realtime, what);
			end
		endfunction

		function void set_threshold(reg_index_t idx, logic [31:0] value);
			case (idx)
				REG_MAX_AGE:      cfg.max_age_ms = value;
				REG_MIN_CONF:     cfg.min_confidence = value[15:0];
				REG_MAX_DISAGREE: cfg.max_disagreement = value[15:0];
				REG_MAX_DRIFT:    cfg.max_drift = value[30:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] threshold_value(reg_index_t idx);
			case (idx)
				REG_MAX_AGE:      return cfg.max_age_ms;
				REG_MIN_CONF:     return {16'd0, cfg.min_confidence};
				REG_MAX_DISAGREE: return {16'd0, cfg.max_disagreement};
				default:          return {1'b0, cfg.max_drift};
			endcase
		endfunction

		// Run the checks in gate order and queue the verdict this candidate must produce.
		function void note_candidate(cand_t c);
			reject_code_t code;
			verdict_t     want;
			logic [31:0]  age;
			int           p;
			int           s;
			int           diff;
			int           conf_full;
			int           conf_floor;
			int           split_cap;
			longint       drift;
			longint       drift_cap;
			p = $signed(c.primary_conf);
			s = $signed(c.secondary_conf);
			drift = $signed(c.drift_metric);
			conf_full = CONF_ONE;
			conf_floor = cfg.min_confidence;
			split_cap = cfg.max_disagreement;
			drift_cap = cfg.max_drift;
			age = c.now_ms - c.stamp_ms;
			diff = (p > s) ? p - s : s - p;
			if (c.now_ms < c.stamp_ms) begin
				code = RC_INVALID;
			end else if (age > cfg.max_age_ms) begin
				code = RC_STALE;
			end else if (seen_any && c.seq_number <= last_seq) begin
				code = RC_SEQUENCE;
			end else if (c.nonfinite_flags[1:0] != 2'b00 || p < 0 || p > conf_full ||
			             s < 0 || s > conf_full) begin
				code = RC_INVALID;
			end else if (p < conf_floor || s < conf_floor) begin
				code = RC_LOWCONF;
			end else if (diff > split_cap) begin
				code = RC_DISAGREE;
			end else if (c.nonfinite_flags[2] || drift < 0) begin
				code = RC_INVALID;
			end else if (drift > drift_cap) begin
				code = RC_DRIFT;
			end else begin
				code = RC_NONE;
			end

			// The sequence register follows forward progress regardless of the verdict.
			if (!seen_any || c.seq_number > last_seq) begin
				last_seq = c.seq_number;
				seen_any = 1'b1;
			end

			want.code = code;
			want.escalate = (code != RC_NONE);
			want.accepted = (code == RC_NONE);
			want.escalation_seq = '0;
			if (want.escalate) begin
				reject_count++;
				want.escalation_seq = escalation_count;
				escalation_count++;
			end else begin
				accept_count++;
			end
			want.accept_total = accept_count;
			want.reject_total = reject_count;
			pending_verdicts.push_back(want);
		endfunction

		// Compare one delivered verdict with the oldest prediction.
		function void check_verdict(verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict with no candidate outstanding, code %0d",
					got.code));
				return;
			end
			want = pending_verdicts.pop_front();
			checked++;
			if (want.accepted) accepts_seen++;
			reject_hits[want.code]++;
			if (got.accepted !== want.accepted)
				report_mismatch($sformatf("verdict %0d accepted: expected %0b, got %0b",
					checked, want.accepted, got.accepted));
			if (got.code !== want.code)
				report_mismatch($sformatf("verdict %0d reject_code: expected %0d, got %0d",
					checked, want.code, got.code));
			if (got.escalate !== want.escalate)
				report_mismatch($sformatf("verdict %0d escalate: expected %0b, got %0b",
					checked, want.escalate, got.escalate));
			if (got.escalation_seq !== want.escalation_seq)
				report_mismatch($sformatf("verdict %0d escalation_seq: expected %0d, got %0d",
					checked, want.escalation_seq, got.escalation_seq));
			if (got.accept_total !== want.accept_total)
				report_mismatch($sformatf("verdict %0d accept_total: expected %0d, got %0d",
					checked, want.accept_total, got.accept_total));
			if (got.reject_total !== want.reject_total)
				report_mismatch($sformatf("verdict %0d reject_total: expected %0d, got %0d",
					checked, want.reject_total, got.reject_total));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned cycle_count = 0;
	logic [31:0] now_clk;
	logic [31:0] seq_top;
	logic        tx_calm;

	verdict_scoreboard sb = new();

	ppg_cand_if    cand_ch();
	ppg_verdict_if verdict_ch();

	perception_plausibility_gate DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cand    (cand_ch),
		.verdict (verdict_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Free-running 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle counter with a hard stop for a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped at %0d cycles with %0d verdicts outstanding",
				cycle_count, sb.pending());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Sample both channels at the rising edge and feed the scoreboard.
	always @(posedge clk) begin
		verdict_t got;
		if (arst_n === 1'b1) begin
			if (cand_ch.valid && cand_ch.ready) begin
				sb.note_candidate(cand_t'{cand_ch.now_ms, cand_ch.stamp_ms,
					cand_ch.seq_number, cand_ch.primary_conf, cand_ch.secondary_conf,
					cand_ch.drift_metric, cand_ch.nonfinite_flags});
			end
			if (verdict_ch.valid && verdict_ch.ready) begin
				got.accepted = verdict_ch.accepted;
				got.code = reject_code_t'(verdict_ch.reject_code);
				got.escalate = verdict_ch.escalate;
				got.escalation_seq = verdict_ch.escalation_seq;
				got.accept_total = verdict_ch.accept_total;
				got.reject_total = verdict_ch.reject_total;
				sb.check_verdict(got);
			end
		end
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned tx_gap();
		if (tx_calm) return 0;
		return ($urandom_range(0, 99) < 35) ? pick_gap() : 0;
	endfunction

	// Verdict-side backpressure, with calm windows where ready stays high.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		verdict_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && (cycle_count % 2000) >= 300 &&
			    $urandom_range(0, 99) < 20) begin
				stall_left = pick_gap();
			end
			verdict_ch.ready <= (stall_left == 0);
			if (stall_left != 0) stall_left--;
		end
	end

	// Present one candidate after an optional gap and hold it until accepted.
	task automatic offer_candidate(input cand_t c, input int unsigned gap);
		@(negedge clk);
		if (gap != 0) begin
			cand_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cand_ch.valid           <= 1'b1;
		cand_ch.now_ms          <= c.now_ms;
		cand_ch.stamp_ms        <= c.stamp_ms;
		cand_ch.seq_number      <= c.seq_number;
		cand_ch.primary_conf    <= c.primary_conf;
		cand_ch.secondary_conf  <= c.secondary_conf;
		cand_ch.drift_metric    <= c.drift_metric;
		cand_ch.nonfinite_flags <= c.nonfinite_flags;
		@(posedge clk);
		while (!cand_ch.ready) @(posedge clk);
	endtask

	// Stop sending and wait until every verdict has come back.
	task automatic drain();
		@(negedge clk);
		cand_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_transfer(input reg_index_t idx, input logic is_write,
		input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic verify_register(input reg_index_t idx);
		logic [31:0] rdata;
		apb_transfer(idx, 1'b0, '0, rdata);
		if (rdata !== sb.threshold_value(idx))
			sb.report_mismatch($sformatf("register %s reads %0h, expected %0h",
				idx.name(), rdata, sb.threshold_value(idx)));
	endtask

	task automatic write_threshold(input reg_index_t idx, input logic [31:0] value);
		logic [31:0] unused;
		apb_transfer(idx, 1'b1, value, unused);
		sb.set_threshold(idx, value);
		verify_register(idx);
	endtask

	// Threshold set for each random phase; the first three are the corner settings.
	task automatic program_phase(input int unsigned phase);
		case (phase)
			1: begin
				write_threshold(REG_MAX_AGE, 32'd0);
				write_threshold(REG_MIN_CONF, 32'd0);
				write_threshold(REG_MAX_DISAGREE, 32'd0);
				write_threshold(REG_MAX_DRIFT, 32'd0);
			end
			2: begin
				write_threshold(REG_MAX_AGE, 32'hFFFF_FFFF);
				write_threshold(REG_MIN_CONF, 32'hFFFF_FFFF);
				write_threshold(REG_MAX_DISAGREE, 32'hFFFF_FFFF);
				write_threshold(REG_MAX_DRIFT, 32'hFFFF_FFFF);
			end
			3: begin
				write_threshold(REG_MAX_AGE, 32'd1000);
				write_threshold(REG_MIN_CONF, 32'd32768);
				write_threshold(REG_MAX_DISAGREE, 32'd32768);
				write_threshold(REG_MAX_DRIFT, 32'h0001_0000);
			end
			default: begin
				write_threshold(REG_MAX_AGE, $urandom_range(0, 5000));
				write_threshold(REG_MIN_CONF, $urandom_range(0, 32768));
				write_threshold(REG_MAX_DISAGREE, $urandom_range(0, 40000));
				write_threshold(REG_MAX_DRIFT, $urandom_range(0, 32'h0010_0000));
			end
		endcase
	endtask

	// Mostly plausible candidates that follow the current thresholds, one check at a
	// time spoiled on purpose, plus a share of fully random noise.
	function automatic cand_t build_candidate(input logic [2:0] region);
		cand_t       c;
		cfg_t        th;
		fault_t      fault;
		int unsigned pick;
		logic [31:0] age;
		logic [31:0] age_cap;
		logic [31:0] drift_cap;
		int          conf_full;
		int          conf_lo;
		int          spread;
		int          p;
		int          s;
		int          s_lo;
		int          s_hi;
		th = sb.cfg;
		c = '0;
		conf_full = CONF_ONE;
		if ($urandom_range(0, 99) < 20) begin
			c.now_ms          = $urandom;
			c.stamp_ms        = $urandom;
			c.seq_number      = {region, 29'($urandom_range(0, 29'h1FFF_0000))};
			c.primary_conf    = 17'($urandom);
			c.secondary_conf  = 17'($urandom);
			c.drift_metric    = $urandom;
			c.nonfinite_flags = 3'($urandom);
		end else begin
			pick = $urandom_range(0, 99);
			fault = (pick < 55) ? F_CLEAN : fault_t'((pick - 55) / 5 + 1);

			// Freshness: age within the limit, at it, or just past it.
			now_clk += $urandom_range(0, 50);
			age_cap = (th.max_age_ms > 32'd500) ? 32'd500 : th.max_age_ms;
			age = ($urandom_range(0, 3) == 0) ? th.max_age_ms : $urandom_range(0, age_cap);
			if (fault == F_STALE && th.max_age_ms != 32'hFFFF_FFFF) age = th.max_age_ms + 1;
			if (age > now_clk) now_clk = age;
			c.now_ms = now_clk;
			c.stamp_ms = now_clk - age;
			if (fault == F_FUTURE) c.stamp_ms = now_clk + $urandom_range(1, 1000);

			// Sequence: step forward, or replay one at or below the last.
			if (fault == F_REPLAY) begin
				c.seq_number = seq_top - $urandom_range(0, 3);
			end else begin
				seq_top += $urandom_range(1, 4);
				c.seq_number = seq_top;
			end

			// Confidences: both at or above the floor and no further apart than allowed.
			conf_lo = (th.min_confidence > CONF_ONE) ? conf_full : th.min_confidence;
			spread = (th.max_disagreement > CONF_ONE) ? conf_full : th.max_disagreement;
			p = $urandom_range(conf_lo, conf_full);
			s_lo = (p - spread > conf_lo) ? p - spread : conf_lo;
			s_hi = (p + spread < conf_full) ? p + spread : conf_full;
			case ($urandom_range(0, 3))
				0: s = s_lo;
				1: s = s_hi;
				default: s = $urandom_range(s_lo, s_hi);
			endcase

			// Drift: anywhere up to the limit, often right at it.
			drift_cap = {1'b0, th.max_drift};
			c.drift_metric = ($urandom_range(0, 3) == 0) ? drift_cap :
				$urandom_range(0, drift_cap);

			case (fault)
				F_RANGE: begin
					if ($urandom_range(0, 1)) p = -int'($urandom_range(1, 65536));
					else s = $urandom_range(conf_full + 1, 65535);
				end
				F_LOWCONF: begin
					if (conf_lo > 0) begin
						if ($urandom_range(0, 1)) p = $urandom_range(0, conf_lo - 1);
						else s = $urandom_range(0, conf_lo - 1);
					end
				end
				F_SPLIT: begin
					if (p - spread - 1 >= 0) s = p - spread - 1;
					else if (p + spread + 1 <= conf_full) s = p + spread + 1;
				end
				F_BADDRIFT: begin
					if ($urandom_range(0, 1)) c.drift_metric = $urandom | 32'h8000_0000;
					else c.nonfinite_flags = 3'b100;
				end
				F_OVERDRIFT: begin
					if (drift_cap != 32'h7FFF_FFFF)
						c.drift_metric = $urandom_range(drift_cap + 1, 32'h7FFF_FFFF);
				end
				F_FLAGS: c.nonfinite_flags = 3'($urandom);
				default: ;
			endcase
			c.primary_conf = 17'(p);
			c.secondary_conf = 17'(s);
		end
		if (c.seq_number > seq_top) seq_top = c.seq_number;
		return c;
	endfunction

	// Main sequence: reset, register check, directed candidates, random phases.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cand_ch.valid = 1'b0;
		cand_ch.now_ms = '0;
		cand_ch.stamp_ms = '0;
		cand_ch.seq_number = '0;
		cand_ch.primary_conf = '0;
		cand_ch.secondary_conf = '0;
		cand_ch.drift_metric = '0;
		cand_ch.nonfinite_flags = '0;
		now_clk = '0;
		seq_top = 32'd100;
		tx_calm = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Registers must come out of reset at their documented values.
		verify_register(REG_MAX_AGE);
		verify_register(REG_MIN_CONF);
		verify_register(REG_MAX_DISAGREE);
		verify_register(REG_MAX_DRIFT);

		// Directed candidates against the reset thresholds.
		offer_candidate(cand_t'{32'd0, 32'd0, 32'd0, 17'sd32768, 17'sd32768,
			32'sd0, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1001, 32'd1, 17'sd20000, 17'sd20000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd900, 32'd2, 17'sd20000, 17'sd20000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd899, 32'd3, 17'sd20000, 17'sd20000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd3, 17'sd20000, 17'sd20000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd2, 17'sd20000, 17'sd20000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd4, -17'sd1, 17'sd20000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd5, 17'sd20000, 17'sd32769,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd6, 17'sh10000, 17'sd65535,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd7, 17'sd20000, 17'sd20000,
			32'sd100, 3'b001}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd8, 17'sd20000, 17'sd20000,
			32'sd100, 3'b010}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd0, 32'd9, 17'sd20000, 17'sd20000,
			32'sd100, 3'b100}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd10, 17'sd16383, 17'sd20000,
			32'sd100, 3'b100}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd11, 17'sd16384, 17'sd16384,
			32'sd65536, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd12, 17'sd20000, 17'sd16383,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd13, 17'sd30000, 17'sd23446,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd14, 17'sd30000, 17'sd23445,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd15, 17'sd23445, 17'sd30000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd16, 17'sd20000, 17'sd20000,
			32'sd100, 3'b100}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd17, 17'sd20000, 17'sd20000,
			32'hFFFF_FFFF, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd18, 17'sd20000, 17'sd20000,
			32'h8000_0000, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd19, 17'sd20000, 17'sd20000,
			32'sd65537, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd1000, 32'd1000, 32'd20, 17'sd20000, 17'sd20000,
			32'h7FFF_FFFF, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd21, 17'sd20000,
			17'sd20000, 32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'hFFFF_FFFF, 32'd0, 32'd22, 17'sd20000, 17'sd20000,
			32'sd100, 3'b000}, tx_gap());
		offer_candidate(cand_t'{32'd0, 32'hFFFF_FFFF, 32'd23, 17'sd20000, 17'sd20000,
			32'sd100, 3'b111}, tx_gap());
		drain();

		// Random phases, each under its own threshold set and sequence region.
		for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase != 0) program_phase(phase);
			if (seq_top < {phase[2:0], 29'd0}) seq_top = {phase[2:0], 29'd0};
			now_clk = $urandom;
			for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
				tx_calm = (i < 25);
				offer_candidate(build_candidate(phase[2:0]), tx_gap());
			end
			tx_calm = 1'b0;
			drain();
		end
		repeat (8) @(posedge clk);

		$display("Gate run: %0d verdicts checked, %0d accepted, %0d rejected, %0d settings",
			sb.checked, sb.accepts_seen, sb.checked - sb.accepts_seen, PHASE_COUNT);
		$display("Rejects: invalid %0d, stale %0d, sequence %0d, low conf %0d, split %0d, drift %0d",
			sb.reject_hits[RC_INVALID], sb.reject_hits[RC_STALE], sb.reject_hits[RC_SEQUENCE],
			sb.reject_hits[RC_LOWCONF], sb.reject_hits[RC_DISAGREE], sb.reject_hits[RC_DRIFT]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d verdicts never arrived", sb.errors, sb.pending());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
